>>> rtl/rei_pkg.sv
// Package for the rotary encoder input block: event codes, result bundle,
// quadrature table and fixed widths. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rei_pkg;

  localparam int unsigned STEPS_PER_DETENT = 4;
  localparam int unsigned QDEPTH           = 4;
  localparam int unsigned QPTR_W           = $clog2(QDEPTH);

  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 24;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEBOUNCE  = 2'd0,
    REG_LONGPRESS = 2'd1,
    REG_ENABLE    = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    EV_TURN  = 2'd0,
    EV_CLICK = 2'd1,
    EV_LONG  = 2'd2
  } ev_t;

  // Results caused by one poll item: first result, optional second one.
  // The second result is always a click or a long press, detents zero.
  typedef struct packed {
    logic        two;
    ev_t         ev0;
    logic [15:0] det0;
    ev_t         ev1;
  } res_bundle_t;

  // Step from {prev_ab, ab}: A in bit 1, B in bit 0.
  localparam logic signed [1:0] QUAD_TABLE [16] = '{
     2'sd0, -2'sd1,  2'sd1,  2'sd0,
     2'sd1,  2'sd0,  2'sd0, -2'sd1,
    -2'sd1,  2'sd0,  2'sd0,  2'sd1,
     2'sd0,  2'sd1, -2'sd1,  2'sd0
  };

endpackage

`default_nettype wire

>>> rtl/rei_front.sv
// Front part: takes input items and config writes, decodes the encoder,
// debounces the button and pushes the results of a poll into the queue.
// Depends on rei_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rei_front (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic                           kind,
  input  wire logic                           pin_a,
  input  wire logic                           pin_b,
  input  wire logic                           button_level,
  input  wire logic [31:0]                    now_ms,
  input  wire logic                           cfg_valid,
  input  wire logic [rei_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [rei_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                           q_full,
  output logic                                q_push,
  output rei_pkg::res_bundle_t                q_data
);
  import rei_pkg::*;

  logic [7:0]  debounce_ms_r;
  logic [15:0] long_press_ms_r;
  logic        events_en_r;

  logic [1:0]  prev_ab_r,  prev_ab_nxt;
  logic [31:0] raw_cnt_r,  raw_cnt_nxt;
  logic [31:0] rep_cnt_r,  rep_cnt_nxt;
  logic        cand_lvl_r, cand_lvl_nxt;
  logic [31:0] cand_since_r, cand_since_nxt;
  logic        held_r,     held_nxt;
  logic [31:0] held_since_r, held_since_nxt;
  logic        long_fired_r, long_fired_nxt;

  logic              accept;
  logic [1:0]        ab;
  logic signed [1:0] step;
  logic [31:0]       diff, mag, quo, squo;
  logic              neg, turn, btn_ev, pressed, btn_down;
  ev_t               btn_code;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign ab       = {pin_a, pin_b};
  assign step     = QUAD_TABLE[{prev_ab_r, ab}];

  // Turn: signed move divided toward zero
  assign diff = raw_cnt_r - rep_cnt_r;
  assign neg  = diff[31];
  assign mag  = neg ? (32'd0 - diff) : diff;
  assign quo  = mag / STEPS_PER_DETENT;
  assign squo = neg ? (32'd0 - quo) : quo;
  assign turn = (quo != 32'd0);
  assign btn_down = !button_level;

  always_comb begin
    prev_ab_nxt    = prev_ab_r;
    raw_cnt_nxt    = raw_cnt_r;
    rep_cnt_nxt    = rep_cnt_r;
    cand_lvl_nxt   = cand_lvl_r;
    cand_since_nxt = cand_since_r;
    held_nxt       = held_r;
    held_since_nxt = held_since_r;
    long_fired_nxt = long_fired_r;
    pressed        = held_r;
    btn_ev         = 1'b0;
    btn_code       = EV_CLICK;
    if (accept && !kind) begin
      prev_ab_nxt = ab;
      raw_cnt_nxt = raw_cnt_r + {{30{step[1]}}, step};
    end else if (accept && kind) begin
      if (turn) begin
        rep_cnt_nxt = rep_cnt_r + (squo * STEPS_PER_DETENT);
      end
      if (btn_down != cand_lvl_r) begin
        cand_lvl_nxt   = btn_down;
        cand_since_nxt = now_ms;
      end
      if ((cand_lvl_nxt != held_r) &&
          ((now_ms - cand_since_nxt) >= {24'd0, debounce_ms_r})) begin
        pressed = cand_lvl_nxt;
      end
      if (pressed && !held_r) begin
        held_nxt       = 1'b1;
        held_since_nxt = now_ms;
        long_fired_nxt = 1'b0;
      end else if (pressed && held_r) begin
        if (!long_fired_r && ((now_ms - held_since_r) >= {16'd0, long_press_ms_r})) begin
          long_fired_nxt = 1'b1;
          btn_ev         = 1'b1;
          btn_code       = EV_LONG;
        end
      end else if (!pressed && held_r) begin
        held_nxt = 1'b0;
        btn_ev   = !long_fired_r;
        btn_code = EV_CLICK;
      end
    end
  end

  // Pack the poll results, turn first
  always_comb begin
    q_data.two  = turn && btn_ev;
    q_data.ev0  = turn ? EV_TURN : btn_code;
    q_data.det0 = turn ? squo[15:0] : 16'd0;
    q_data.ev1  = btn_code;
    q_push      = accept && kind && events_en_r && (turn || btn_ev);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_ms_r   <= 8'd25;
      long_press_ms_r <= 16'd500;
      events_en_r     <= 1'b0;
      prev_ab_r       <= '0;
      raw_cnt_r       <= '0;
      rep_cnt_r       <= '0;
      cand_lvl_r      <= 1'b0;
      cand_since_r    <= '0;
      held_r          <= 1'b0;
      held_since_r    <= '0;
      long_fired_r    <= 1'b0;
    end else begin
      prev_ab_r    <= prev_ab_nxt;
      raw_cnt_r    <= raw_cnt_nxt;
      rep_cnt_r    <= rep_cnt_nxt;
      cand_lvl_r   <= cand_lvl_nxt;
      cand_since_r <= cand_since_nxt;
      held_r       <= held_nxt;
      held_since_r <= held_since_nxt;
      long_fired_r <= long_fired_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          REG_DEBOUNCE:  debounce_ms_r   <= cfg_data[7:0];
          REG_LONGPRESS: long_press_ms_r <= cfg_data;
          REG_ENABLE:    events_en_r     <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/rei_queue.sv
// Short FIFO of result bundles between front and back.
// Depends on rei_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rei_queue (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  input  wire rei_pkg::res_bundle_t push_data,
  input  wire logic                 pop,
  output rei_pkg::res_bundle_t      pop_data,
  output logic                      full,
  output logic                      empty
);
  import rei_pkg::*;

  res_bundle_t             mem_r [QDEPTH];
  logic [QPTR_W-1:0]       wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]         cnt_r, cnt_nxt;
  logic                    do_push, do_pop;

  assign full     = (cnt_r == QDEPTH[QPTR_W:0]);
  assign empty    = (cnt_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) cnt_nxt = cnt_r + 1'b1;
    else if (!do_push && do_pop) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
    end
  end

endmodule

`default_nettype wire

>>> rtl/rei_back.sv
// Back part: unpacks result bundles into single results on the output
// register, one per cycle while out_ready is high. Depends on rei_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rei_back (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 q_empty,
  input  wire rei_pkg::res_bundle_t q_data,
  output logic                      q_pop,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output rei_pkg::ev_t              out_ev,
  output logic [15:0]               out_det,
  output logic                      out_last
);
  import rei_pkg::*;

  logic        valid_r, valid_nxt;
  logic        pend_r,  pend_nxt;
  ev_t         pend_ev_r;
  ev_t         ev_r;
  logic [15:0] det_r;
  logic        last_r;
  logic        slot_free;

  assign slot_free = !valid_r || out_ready;
  assign q_pop     = slot_free && !pend_r && !q_empty;
  assign out_valid = valid_r;
  assign out_ev    = ev_r;
  assign out_det   = det_r;
  assign out_last  = last_r;

  always_comb begin
    valid_nxt = valid_r;
    pend_nxt  = pend_r;
    if (slot_free) begin
      if (pend_r) begin
        valid_nxt = 1'b1;
        pend_nxt  = 1'b0;
      end else begin
        valid_nxt = !q_empty;
        pend_nxt  = !q_empty && q_data.two;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (slot_free && pend_r) begin
      ev_r   <= pend_ev_r;
      det_r  <= 16'd0;
      last_r <= 1'b1;
    end else if (q_pop) begin
      ev_r      <= q_data.ev0;
      det_r     <= q_data.det0;
      last_r    <= !q_data.two;
      pend_ev_r <= q_data.ev1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      pend_r  <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      pend_r  <= pend_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/rotary_encoder_input_top.sv
// Rotary encoder and push-button input block, top level.
// Depends on rei_pkg, rei_front, rei_queue, rei_back.
//
// Encoder samples (tuser 0) and polls with time and button level (tuser 1)
// are taken one per cycle and processed in the cycle they are accepted; a
// poll may cause a turn result and then a click or long-press result. The
// results wait in a four-deep queue and leave through a registered output
// at one per cycle while out_tready is high, so the two results of a poll
// leave one after the other. Input is only stalled when the queue is full.
// Configuration writes are always accepted (cfg_ready is tied high).
`timescale 1ns / 1ps
`default_nettype none

module rotary_encoder_input_top (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  // [0] pin_a, [1] pin_b, [2] button_level, [34:3] now_ms, [39:35] zero
  input  wire logic [rei_pkg::IN_TDATA_W-1:0] in_tdata,
  // [0] kind
  input  wire logic                           in_tuser,
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  // [1:0] event_res, [17:2] detents, [23:18] zero
  output logic [rei_pkg::OUT_TDATA_W-1:0]     out_tdata,
  output logic                                out_tlast,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [rei_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [rei_pkg::CFG_DATA_W-1:0] cfg_data
);
  import rei_pkg::*;

  res_bundle_t push_data, pop_data;
  logic        q_push, q_pop, q_full, q_empty;
  ev_t         ev;
  logic [15:0] det;

  assign cfg_ready = 1'b1;

  rei_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .kind         (in_tuser),
    .pin_a        (in_tdata[0]),
    .pin_b        (in_tdata[1]),
    .button_level (in_tdata[2]),
    .now_ms       (in_tdata[34:3]),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_data       (push_data)
  );

  rei_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (push_data),
    .pop       (q_pop),
    .pop_data  (pop_data),
    .full      (q_full),
    .empty     (q_empty)
  );

  rei_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_data    (pop_data),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_ev    (ev),
    .out_det   (det),
    .out_last  (out_tlast)
  );

  assign out_tdata = {6'd0, det, ev};

endmodule

`default_nettype wire
